// ===== hdl/oale_pkg.sv =====
// ----------------------------------------------------------------------------
// oale_pkg
// shared types and constants of the ordered array list engine: command
// codes, status codes and the controller to datapath command and status
// ----------------------------------------------------------------------------
package oale_pkg;

    localparam int CMD_W       = 3;
    localparam int POS_W       = 6;
    localparam int VAL_W       = 32;
    localparam int CAP_W       = 7;
    localparam int CNT_OUT_W   = 7;
    localparam int DEFAULT_CAP = 10;

    localparam logic [CAP_W-1:0] CAP_RESET         = 7'd64;
    localparam logic [1:0]       REG_CAPACITY_ADDR = 2'd0;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_EDIT   = 3'd2,
        CMD_DELETE = 3'd3,
        CMD_GET    = 3'd4,
        CMD_FIND   = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_BADPOS   = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_APPEND,
        DP_PUT,
        DP_PUT_INC,
        DP_DEC,
        DP_START_UP,
        DP_START_DN,
        DP_START_FIND,
        DP_STEP,
        DP_GET_RD,
        DP_GET_CAP,
        DP_FAIL,
        DP_PUBLISH
    } t_dp_op;

    typedef struct packed {
        t_dp_op  op;
        t_status code;
    } t_dp_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic full;
        logic pos_gt_cnt;
        logic pos_ge_cnt;
        logic pos_eq_cnt;
        logic pos_is_last;
        logic cnt_zero;
        logic more;
        logic rv;
        logic hit;
    } t_dp_stat;

endpackage

// ===== hdl/oale_dp.sv =====
// ----------------------------------------------------------------------------
// oale_dp
// datapath: entry memory, occupancy count, scan pointers and the result
// and output registers; carries out one controller command per cycle
// ----------------------------------------------------------------------------
module oale_dp import oale_pkg::*; #(
    parameter int DEPTH     = 64,
    parameter int WORD_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat,
    input  logic [CAP_W-1:0]     i_capacity,
    input  logic [CMD_W-1:0]     i_in_cmd,
    input  logic [POS_W-1:0]     i_in_pos,
    input  logic [VAL_W-1:0]     i_in_val,
    output t_status              o_status,
    output logic [VAL_W-1:0]     o_read_value,
    output logic                 o_found,
    output logic [POS_W-1:0]     o_found_position,
    output logic [CNT_OUT_W-1:0] o_entry_count,
    output logic                 o_is_empty,
    output logic                 o_is_full
);

    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int CW      = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int XW      = (WORD_BITS > VAL_W) ? WORD_BITS : VAL_W;
    localparam int FW      = (AW > POS_W) ? AW : POS_W;
    localparam int DEF_CAP = (DEPTH < DEFAULT_CAP) ? DEPTH : DEFAULT_CAP;

    logic [WORD_BITS-1:0] r_mem [DEPTH];

    t_cmd                 r_cmd;
    logic [POS_W-1:0]     r_pos;
    logic [WORD_BITS-1:0] r_val;
    logic [CNT_W-1:0]     r_count;
    logic [CW-1:0]        r_ra;
    logic [AW-1:0]        r_wa;
    logic                 r_rv;
    logic                 r_more;
    logic [WORD_BITS-1:0] r_rdata;
    t_status              r_status;
    logic [WORD_BITS-1:0] r_read;
    logic                 r_found;
    logic [AW-1:0]        r_fpos;

    t_status              r_o_status;
    logic [VAL_W-1:0]     r_o_read;
    logic                 r_o_found;
    logic [POS_W-1:0]     r_o_fpos;
    logic [CNT_OUT_W-1:0] r_o_count;
    logic                 r_o_empty;
    logic                 r_o_full;

    logic [CW-1:0]        cnt_x;
    logic [CW-1:0]        pos_x;
    logic [CW-1:0]        cap_x;
    logic [CW-1:0]        eff_cap;
    logic                 full;
    logic                 up;
    logic                 ra_last;
    logic [CW-1:0]        ra_step;
    logic                 hit;
    logic signed [XW-1:0] val_x;
    logic [XW-1:0]        rd_x;
    logic [FW-1:0]        fp_x;

    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [WORD_BITS-1:0] wr_data;

    assign cnt_x   = CW'(r_count);
    assign pos_x   = CW'(r_pos);
    assign cap_x   = CW'(i_capacity);
    assign eff_cap = (i_capacity == '0) ? CW'(DEF_CAP) :
                     ((cap_x > CW'(DEPTH)) ? CW'(DEPTH) : cap_x);
    assign full    = (cnt_x >= eff_cap);
    assign up      = (r_cmd == CMD_INSERT);
    assign ra_last = up ? (r_ra == pos_x) : (r_ra == cnt_x - CW'(1));
    assign ra_step = up ? (r_ra - CW'(1)) : (r_ra + CW'(1));
    assign hit     = r_rv && (r_rdata == r_val);
    assign val_x   = XW'($signed(i_in_val));
    assign rd_x    = XW'(r_read);
    assign fp_x    = FW'(r_fpos);

    assign o_stat.cmd         = r_cmd;
    assign o_stat.full        = full;
    assign o_stat.pos_gt_cnt  = (pos_x > cnt_x);
    assign o_stat.pos_ge_cnt  = (pos_x >= cnt_x);
    assign o_stat.pos_eq_cnt  = (pos_x == cnt_x);
    assign o_stat.pos_is_last = ((pos_x + CW'(1)) == cnt_x);
    assign o_stat.cnt_zero    = (r_count == '0);
    assign o_stat.more        = r_more;
    assign o_stat.rv          = r_rv;
    assign o_stat.hit         = hit;

    // memory port selection
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_ra[AW-1:0];
        wr_en   = 1'b0;
        wr_addr = pos_x[AW-1:0];
        wr_data = r_val;
        unique case (i_cmd.op)
            DP_APPEND: begin
                wr_en   = 1'b1;
                wr_addr = cnt_x[AW-1:0];
            end
            DP_PUT, DP_PUT_INC: begin
                wr_en = 1'b1;
            end
            DP_GET_RD: begin
                rd_en   = 1'b1;
                rd_addr = pos_x[AW-1:0];
            end
            DP_STEP: begin
                rd_en   = r_more;
                wr_en   = r_rv && (r_cmd != CMD_FIND);
                wr_addr = up ? (r_wa + AW'(1)) : (r_wa - AW'(1));
                wr_data = r_rdata;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_rv    <= 1'b0;
            r_more  <= 1'b0;
        end else begin
            unique case (i_cmd.op)
                DP_LOAD: begin
                    r_cmd    <= t_cmd'(i_in_cmd);
                    r_pos    <= i_in_pos;
                    r_val    <= val_x[WORD_BITS-1:0];
                    r_status <= ST_OK;
                    r_read   <= '0;
                    r_found  <= 1'b0;
                    r_fpos   <= '0;
                end
                DP_APPEND, DP_PUT_INC: begin
                    r_count <= r_count + CNT_W'(1);
                end
                DP_DEC: begin
                    r_count <= r_count - CNT_W'(1);
                end
                DP_START_UP: begin
                    r_ra   <= cnt_x - CW'(1);
                    r_more <= 1'b1;
                    r_rv   <= 1'b0;
                end
                DP_START_DN: begin
                    r_ra   <= pos_x + CW'(1);
                    r_more <= 1'b1;
                    r_rv   <= 1'b0;
                end
                DP_START_FIND: begin
                    r_ra   <= '0;
                    r_more <= 1'b1;
                    r_rv   <= 1'b0;
                end
                DP_STEP: begin
                    if (r_more) begin
                        r_wa   <= r_ra[AW-1:0];
                        r_rv   <= 1'b1;
                        r_ra   <= ra_step;
                        r_more <= !ra_last;
                    end else begin
                        r_rv <= 1'b0;
                    end
                    if ((r_cmd == CMD_FIND) && hit) begin
                        r_found <= 1'b1;
                        r_fpos  <= r_wa;
                    end
                end
                DP_GET_CAP: begin
                    r_read <= r_rdata;
                end
                DP_FAIL: begin
                    r_status <= i_cmd.code;
                end
                DP_PUBLISH: begin
                    r_o_status <= r_status;
                    r_o_read   <= rd_x[VAL_W-1:0];
                    r_o_found  <= r_found;
                    r_o_fpos   <= fp_x[POS_W-1:0];
                    r_o_count  <= cnt_x[CNT_OUT_W-1:0];
                    r_o_empty  <= (r_count == '0);
                    r_o_full   <= full;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_status         = r_o_status;
    assign o_read_value     = r_o_read;
    assign o_found          = r_o_found;
    assign o_found_position = r_o_fpos;
    assign o_entry_count    = r_o_count;
    assign o_is_empty       = r_o_empty;
    assign o_is_full        = r_o_full;

endmodule

// ===== hdl/oale_ctrl.sv =====
// ----------------------------------------------------------------------------
// oale_ctrl
// controller: takes a command, checks it against the list state and steps
// the datapath through the write, shift, read or search sequence
// ----------------------------------------------------------------------------
module oale_ctrl import oale_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_valid,
    output logic     o_s_ready,
    output logic     o_m_valid,
    input  logic     i_m_ready,
    output t_dp_cmd  o_dp,
    input  t_dp_stat i_stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_SHIFT,
        S_FIND,
        S_GETW,
        S_DONE
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_m_valid;
    t_dp_cmd dp;

    always_comb begin
        n_state = r_state;
        dp.op   = DP_NOP;
        dp.code = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    dp.op   = DP_LOAD;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = S_DONE;
                unique case (i_stat.cmd)
                    CMD_APPEND: begin
                        if (i_stat.full) begin
                            dp.op   = DP_FAIL;
                            dp.code = ST_OVERFLOW;
                        end else begin
                            dp.op = DP_APPEND;
                        end
                    end
                    CMD_INSERT: begin
                        priority if (i_stat.pos_gt_cnt) begin
                            dp.op   = DP_FAIL;
                            dp.code = ST_BADPOS;
                        end else if (i_stat.full) begin
                            dp.op   = DP_FAIL;
                            dp.code = ST_OVERFLOW;
                        end else if (i_stat.pos_eq_cnt) begin
                            dp.op = DP_PUT_INC;
                        end else begin
                            dp.op   = DP_START_UP;
                            n_state = S_SHIFT;
                        end
                    end
                    CMD_EDIT: begin
                        if (i_stat.pos_ge_cnt) begin
                            dp.op   = DP_FAIL;
                            dp.code = ST_BADPOS;
                        end else begin
                            dp.op = DP_PUT;
                        end
                    end
                    CMD_DELETE: begin
                        priority if (i_stat.pos_ge_cnt) begin
                            dp.op   = DP_FAIL;
                            dp.code = ST_BADPOS;
                        end else if (i_stat.pos_is_last) begin
                            dp.op = DP_DEC;
                        end else begin
                            dp.op   = DP_START_DN;
                            n_state = S_SHIFT;
                        end
                    end
                    CMD_GET: begin
                        if (i_stat.pos_ge_cnt) begin
                            dp.op   = DP_FAIL;
                            dp.code = ST_BADPOS;
                        end else begin
                            dp.op   = DP_GET_RD;
                            n_state = S_GETW;
                        end
                    end
                    CMD_FIND: begin
                        if (!i_stat.cnt_zero) begin
                            dp.op   = DP_START_FIND;
                            n_state = S_FIND;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_SHIFT: begin
                if (!i_stat.more && !i_stat.rv) begin
                    dp.op   = (i_stat.cmd == CMD_INSERT) ? DP_PUT_INC : DP_DEC;
                    n_state = S_DONE;
                end else begin
                    dp.op = DP_STEP;
                end
            end
            S_FIND: begin
                dp.op = DP_STEP;
                if (i_stat.hit || (!i_stat.more && !i_stat.rv)) begin
                    n_state = S_DONE;
                end
            end
            S_GETW: begin
                dp.op   = DP_GET_CAP;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_m_valid || i_m_ready) begin
                    dp.op   = DP_PUBLISH;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (dp.op == DP_PUBLISH) begin
                r_m_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    assign o_s_ready = (r_state == S_IDLE);
    assign o_m_valid = r_m_valid;
    assign o_dp      = dp;

endmodule

// ===== hdl/ordered_array_list_engine.sv =====
// ----------------------------------------------------------------------------
// ordered_array_list_engine
// packed ordered list of signed words with append, insert, edit, delete,
// get and find commands, a capacity register and one result per command
// ----------------------------------------------------------------------------
// One command is taken at a time. Append, edit, a rejected command and a find
// on an empty list go from the check straight to the result state; a get
// first captures the word read from memory. Insert and delete move the
// entries above the position one place per cycle through the single entry
// memory, one read and one write a cycle; find reads one entry a cycle from
// position zero and stops at the first hit or after the last entry. The next
// command is taken once the result is in the output register, while it still
// waits to be taken. The capacity register (byte address 0) sets when the
// list counts as full: zero means ten entries, and a value above DEPTH means
// DEPTH.
module ordered_array_list_engine import oale_pkg::*; #(
    parameter int DEPTH     = 64,
    parameter int WORD_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // position[5:0], value[37:6], zero fill
    input  logic [2:0]  i_s_axis_tuser,   // command[2:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // read_value, found, found_position,
                                          // entry_count, is_empty, is_full
    output logic [1:0]  o_m_axis_tuser,   // status[1:0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [CAP_W-1:0]     r_capacity;
    t_dp_cmd              dp_cmd;
    t_dp_stat             dp_stat;
    t_status              m_status;
    logic [VAL_W-1:0]     m_read;
    logic                 m_found;
    logic [POS_W-1:0]     m_fpos;
    logic [CNT_OUT_W-1:0] m_count;
    logic                 m_empty;
    logic                 m_full;

    // capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (psel && penable && pwrite && pready
                     && (paddr == REG_CAPACITY_ADDR)) begin
            r_capacity <= pwdata[CAP_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == REG_CAPACITY_ADDR) ? 32'(r_capacity) : '0;

    oale_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .o_dp      (dp_cmd),
        .i_stat    (dp_stat)
    );

    oale_dp #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .o_stat           (dp_stat),
        .i_capacity       (r_capacity),
        .i_in_cmd         (i_s_axis_tuser),
        .i_in_pos         (i_s_axis_tdata[POS_W-1:0]),
        .i_in_val         (i_s_axis_tdata[POS_W+VAL_W-1:POS_W]),
        .o_status         (m_status),
        .o_read_value     (m_read),
        .o_found          (m_found),
        .o_found_position (m_fpos),
        .o_entry_count    (m_count),
        .o_is_empty       (m_empty),
        .o_is_full        (m_full)
    );

    assign o_m_axis_tdata = {m_full, m_empty, m_count, m_fpos, m_found, m_read};
    assign o_m_axis_tuser = m_status;

`ifndef NO_ASSERTIONS
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("command taken while another is in progress");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && m_found |-> m_status == ST_OK)
        else $error("find hit reported with a failing status");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (m_status == ST_OVERFLOW) |-> m_full)
        else $error("overflow reported on a list that is not full");
`endif

endmodule
